[rtl/espp_pkg.sv]
// ----------------------------------------------------------------------------
// Encoder speed PID controller package
// Shared widths, reset values, register indexes and types.
// ----------------------------------------------------------------------------
package espp_pkg;

   localparam int CNT_W         = 16;
   localparam int SPEED_W       = 20;
   localparam int ERR_W         = 22;
   localparam int GAIN_W        = 16;
   localparam int PROD_W        = GAIN_W + 1 + ERR_W;
   localparam int INTEG_W       = 40;
   localparam int Q_W           = 42;
   localparam int FRAC_W        = 12;
   localparam int DRIVE_VALUE_W = 14;
   localparam int CSR_ADDR_W    = 2;
   localparam int REQ_DATA_W    = 32;
   localparam int RSP_DATA_W    = 40;

   localparam int DRIVE_PERIOD_DEF = 15000;

   localparam logic [GAIN_W-1:0] KP_RESET = 16'd5325;
   localparam logic [GAIN_W-1:0] KD_RESET = 16'd4096;
   localparam logic [GAIN_W-1:0] KI_RESET = 16'd0;

   localparam logic [CSR_ADDR_W-1:0] REG_KP = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_KD = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_KI = 2'd2;

   typedef struct packed {
      logic [GAIN_W-1:0] kp;
      logic [GAIN_W-1:0] kd;
      logic [GAIN_W-1:0] ki;
   } gains_type;

   typedef struct packed {
      logic [SPEED_W-1:0]       measured_speed;
      logic                     pwm_write;
      logic [DRIVE_VALUE_W-1:0] drive_value;
   } result_type;

endpackage

[rtl/espp_csr.sv]
// ----------------------------------------------------------------------------
// Encoder speed PID gain registers
// Holds the proportional, derivative and integral gains written over the
// configuration port.
// ----------------------------------------------------------------------------
module espp_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [espp_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [espp_pkg::GAIN_W-1:0]       csr_wdata,
   output espp_pkg::gains_type               gains
);
   import espp_pkg::*;

   gains_type gains_ff;
   gains_type gains_in;

   always_comb begin
      gains_in = gains_ff;
      if (csr_we) begin
         unique case (csr_addr)
            REG_KP:  gains_in.kp = csr_wdata;
            REG_KD:  gains_in.kd = csr_wdata;
            REG_KI:  gains_in.ki = csr_wdata;
            default: gains_in = gains_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.kp <= KP_RESET;
         gains_ff.kd <= KD_RESET;
         gains_ff.ki <= KI_RESET;
      end else begin
         gains_ff <= gains_in;
      end
   end

   assign gains = gains_ff;

endmodule

[rtl/espp_core.sv]
// ----------------------------------------------------------------------------
// Encoder speed PID datapath
// Measures speed, forms the PID correction, updates the drive and holds the
// controller state, which advances once per processed item.
// ----------------------------------------------------------------------------
module espp_core #(
   parameter int DRIVE_PERIOD = espp_pkg::DRIVE_PERIOD_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [espp_pkg::CNT_W-1:0]    encoder_count,
   input  logic [espp_pkg::CNT_W-1:0]    target_speed,
   input  espp_pkg::gains_type           gains,
   output espp_pkg::result_type          result
);
   import espp_pkg::*;

   localparam int DRIVE_W = (DRIVE_PERIOD > 2) ? $clog2(DRIVE_PERIOD) : 1;
   localparam int ND_W    = Q_W - FRAC_W;
   localparam logic signed [ND_W-1:0]    PERIOD_S  = ND_W'(DRIVE_PERIOD);
   localparam logic [DRIVE_W-1:0]        DRIVE_MAX = DRIVE_W'(DRIVE_PERIOD - 1);
   localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
   localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

   logic        [CNT_W-1:0]   last_count_ff, last_count_in;
   logic signed [ERR_W-1:0]   prev_err_ff, prev_err_in;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic        [DRIVE_W-1:0] drive_ff, drive_in;

   logic        [CNT_W-1:0]          diff;
   logic        [SPEED_W-1:0]        speed;
   logic signed [ERR_W-1:0]          err;
   logic signed [ERR_W-1:0]          derr;
   logic signed [GAIN_W:0]           kp_s, kd_s, ki_s;
   logic signed [PROD_W-1:0]         p_term, d_term, i_term;
   logic signed [INTEG_W:0]          integ_sum;
   logic signed [Q_W-1:0]            q_sum;
   logic signed [ND_W-1:0]           nd;
   logic                             wr;
   logic        [DRIVE_W+DRIVE_VALUE_W-1:0] drive_ext;

   always_comb begin
      diff = (encoder_count >= last_count_ff) ? encoder_count - last_count_ff
                                              : last_count_ff - encoder_count;
      speed = {diff, 4'b0000} - {4'b0000, diff};
      err = $signed({{(ERR_W-CNT_W){1'b0}}, target_speed})
          - $signed({{(ERR_W-SPEED_W){1'b0}}, speed});
      derr = err - prev_err_ff;

      kp_s = $signed({1'b0, gains.kp});
      kd_s = $signed({1'b0, gains.kd});
      ki_s = $signed({1'b0, gains.ki});
      p_term = kp_s * err;
      d_term = kd_s * derr;
      i_term = ki_s * err;

      integ_sum = {integ_ff[INTEG_W-1], integ_ff}
                + {{(INTEG_W+1-PROD_W){i_term[PROD_W-1]}}, i_term};
      priority if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
         integ_in = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
      end else begin
         integ_in = integ_sum[INTEG_W-1:0];
      end

      q_sum = $signed({{(Q_W-FRAC_W-DRIVE_W){1'b0}}, drive_ff, {FRAC_W{1'b0}}})
            + {{(Q_W-PROD_W){p_term[PROD_W-1]}}, p_term}
            + {{(Q_W-PROD_W){d_term[PROD_W-1]}}, d_term}
            + {{(Q_W-INTEG_W){integ_in[INTEG_W-1]}}, integ_in};

      // Division by the Q4.12 unit, rounded toward zero.
      nd = q_sum[Q_W-1:FRAC_W]
         + ND_W'(q_sum[Q_W-1] && (q_sum[FRAC_W-1:0] != '0));

      wr = (nd > 0) && (nd < PERIOD_S);
      priority if (nd >= PERIOD_S) begin
         drive_in = DRIVE_MAX;
      end else if (nd <= 0) begin
         drive_in = '0;
      end else begin
         drive_in = nd[DRIVE_W-1:0];
      end

      last_count_in = encoder_count;
      prev_err_in   = err;

      drive_ext             = {{DRIVE_VALUE_W{1'b0}}, drive_in};
      result.measured_speed = speed;
      result.pwm_write      = wr;
      result.drive_value    = drive_ext[DRIVE_VALUE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_count_ff <= '0;
         prev_err_ff   <= '0;
         integ_ff      <= '0;
         drive_ff      <= '0;
      end else if (advance) begin
         last_count_ff <= last_count_in;
         prev_err_ff   <= prev_err_in;
         integ_ff      <= integ_in;
         drive_ff      <= drive_in;
      end
   end

endmodule

[rtl/encoder_speed_pid_pwm.sv]
// ----------------------------------------------------------------------------
// Encoder speed PID controller with PWM drive
// Takes an encoder count and a target speed per tick and returns the measured
// speed and the new PWM drive.
// ----------------------------------------------------------------------------
// The req channel carries one item per control tick: the encoder count and
// the target speed. The rsp channel returns one item per request: the
// measured speed, the PWM write flag on rsp_tuser and the clamped drive.
// Gains are to be written on the csr port only while no item is in flight;
// the block does not enforce it. An accepted item waits in the input
// register, where the whole PID update is computed; the output register
// then takes its result. One item is taken every cycle while the receiver
// does not stall. Controller state advances as an item leaves the input
// register. Reset clears the pipeline, the controller state and restores
// the default gains. When the receiver stalls, the output register holds
// its item and the input register still takes one more item before
// req_tready drops.
// ----------------------------------------------------------------------------
module encoder_speed_pid_pwm #(
   parameter int DRIVE_PERIOD = espp_pkg::DRIVE_PERIOD_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // encoder_count[15:0], target_speed[31:16]
   input  logic [espp_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // measured_speed[19:0], drive_value[33:20], zero padding above
   output logic [espp_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // pwm_write[0]
   output logic                                 rsp_tuser,
   input  logic                                 csr_we,
   input  logic [espp_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [espp_pkg::GAIN_W-1:0]          csr_wdata
);
   import espp_pkg::*;

   gains_type  gains;
   result_type result;

   logic             s1_valid_ff, s1_valid_in;
   logic [CNT_W-1:0] enc_ff, enc_in;
   logic [CNT_W-1:0] tgt_ff, tgt_in;
   logic             out_valid_ff, out_valid_in;
   result_type       out_ff, out_in;
   logic             out_free;
   logic             s1_adv;
   logic             req_fire;

   espp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .gains     (gains)
   );

   espp_core #(
      .DRIVE_PERIOD (DRIVE_PERIOD)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .advance       (s1_adv),
      .encoder_count (enc_ff),
      .target_speed  (tgt_ff),
      .gains         (gains),
      .result        (result)
   );

   always_comb begin
      out_free   = !out_valid_ff || rsp_tready;
      s1_adv     = s1_valid_ff && out_free;
      req_tready = !s1_valid_ff || out_free;
      req_fire   = req_tvalid && req_tready;

      s1_valid_in = req_fire || (s1_valid_ff && !out_free);
      enc_in      = req_fire ? req_tdata[CNT_W-1:0] : enc_ff;
      tgt_in      = req_fire ? req_tdata[2*CNT_W-1:CNT_W] : tgt_ff;

      out_valid_in = s1_adv || (out_valid_ff && !rsp_tready);
      out_in       = s1_adv ? result : out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      enc_ff <= enc_in;
      tgt_ff <= tgt_in;
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.pwm_write;
   assign rsp_tdata  = {{(RSP_DATA_W-SPEED_W-DRIVE_VALUE_W){1'b0}},
                        out_ff.drive_value, out_ff.measured_speed};

`ifndef SYNTHESIS
   a_write_nonzero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.pwm_write |-> out_ff.drive_value != '0)
      else $error("PWM write flagged with a zero drive");

   a_s1_held: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff)
      else $error("Input register dropped an item under stall");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      req_fire && s1_valid_ff |-> s1_adv)
      else $error("Input register overwritten before it advanced");

   a_result_taken: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> out_valid_ff)
      else $error("Processed item did not reach the output register");
`endif

endmodule

[bench/encoder_speed_pid_pwm_tb.sv]
// ----------------------------------------------------------------------------
// Encoder speed PID controller testbench
// Drives encoder count and target speed items through the PID/PWM block under
// several gain settings and checks each result item against a predictor of
// the speed measurement, the PID update and the drive clamp.
// ----------------------------------------------------------------------------
module encoder_speed_pid_pwm_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import espp_pkg::*;

   localparam int CLK_PERIOD = 10;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRIVE_PERIOD = DRIVE_PERIOD_DEF;
   localparam logic [CSR_ADDR_W-1:0] REG_NONE = 2'd3;
   localparam logic [GAIN_W-1:0] GAIN_MAX = '1;

   typedef enum {STIM_MOTION, STIM_WINDUP} stim_type;

   class pid_tracker_type;
      localparam longint SPEED_SCALE = 15;
      localparam longint FRAC_ONE = longint'(1) << FRAC_W;
      localparam longint INTEG_HI = (longint'(1) << (INTEG_W - 1)) - 1;
      localparam longint INTEG_LO = -INTEG_HI - 1;

      logic [GAIN_W-1:0] kp, kd, ki;
      logic [CNT_W-1:0] prev_count;
      longint prev_error;
      longint integ;
      logic [DRIVE_VALUE_W-1:0] drive;
      result_type due_results[$];
      int errors, checked, ticks, writes, clamp_hi, clamp_lo, sat_hits;

      function new();
         kp = KP_RESET;
         kd = KD_RESET;
         ki = KI_RESET;
         prev_count = '0;
         prev_error = 0;
         integ = 0;
         drive = '0;
      endfunction

      function void load_gains(logic [GAIN_W-1:0] p, logic [GAIN_W-1:0] d,
                               logic [GAIN_W-1:0] i);
         kp = p;
         kd = d;
         ki = i;
      endfunction

      function int pending();
         return due_results.size();
      endfunction

      function void note_tick(logic [CNT_W-1:0] cnt, logic [CNT_W-1:0] tgt);
         longint diff, speed, err, p, d, q, nd;
         logic wr;
         result_type r;
         diff = (cnt >= prev_count) ? longint'(cnt - prev_count)
                                    : longint'(prev_count - cnt);
         speed = diff * SPEED_SCALE;
         prev_count = cnt;
         err = longint'(tgt) - speed;
         p = longint'(kp) * err;
         d = longint'(kd) * (err - prev_error);
         integ = integ + longint'(ki) * err;
         if (integ > INTEG_HI) begin
            integ = INTEG_HI;
            sat_hits++;
         end
         if (integ < INTEG_LO) begin
            integ = INTEG_LO;
            sat_hits++;
         end
         prev_error = err;
         q = longint'(drive) * FRAC_ONE + p + d + integ;
         nd = q / FRAC_ONE;
         wr = (nd > 0) && (nd < DRIVE_PERIOD);
         if (nd >= DRIVE_PERIOD) begin
            nd = DRIVE_PERIOD - 1;
            clamp_hi++;
         end
         if (nd <= 0) begin
            nd = 0;
            clamp_lo++;
         end
         drive = nd[DRIVE_VALUE_W-1:0];
         if (wr) writes++;
         ticks++;
         r.measured_speed = speed[SPEED_W-1:0];
         r.pwm_write = wr;
         r.drive_value = drive;
         due_results.push_back(r);
      endfunction

      task report_mismatch(string what);
         errors++;
         if (errors <= 50) $display("MISMATCH at %0t ns: %s", $time, what);
      endtask

      task check_result(logic [RSP_DATA_W-1:0] data, logic user);
         result_type want;
         logic [SPEED_W-1:0] got_speed;
         logic [DRIVE_VALUE_W-1:0] got_value;
         got_speed = data[SPEED_W-1:0];
         got_value = data[SPEED_W +: DRIVE_VALUE_W];
         if (due_results.size() == 0) begin
            report_mismatch("result item with no request outstanding");
            return;
         end
         want = due_results.pop_front();
         checked++;
         if (got_speed !== want.measured_speed)
            report_mismatch($sformatf("measured_speed got %0d want %0d",
                                      got_speed, want.measured_speed));
         if (user !== want.pwm_write)
            report_mismatch($sformatf("pwm_write got %b want %b", user, want.pwm_write));
         if (got_value !== want.drive_value)
            report_mismatch($sformatf("drive_value got %0d want %0d",
                                      got_value, want.drive_value));
         if (data[RSP_DATA_W-1:SPEED_W+DRIVE_VALUE_W] !== '0)
            report_mismatch($sformatf("padding bits not zero: %h", data));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [GAIN_W-1:0] csr_wdata = '0;

   pid_tracker_type tracker;
   logic [CNT_W-1:0] enc_pos = '0;
   logic [11:0] stall_phase = '0;
   int cycle_count = 0;
   int gain_sets = 0;

   encoder_speed_pid_pwm #(
      .DRIVE_PERIOD(DRIVE_PERIOD)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles.", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_result(rsp_tdata, rsp_tuser);
      stall_phase <= stall_phase + 1'b1;
      case (stall_phase[10:9])
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2'd2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (stall_phase[2:0] < 3'd5);
      endcase
   end

   task automatic send_tick(input logic [CNT_W-1:0] cnt, input logic [CNT_W-1:0] tgt);
      req_tvalid <= 1'b1;
      req_tdata <= {tgt, cnt};
      do @(posedge clock); while (!req_tready);
      tracker.note_tick(cnt, tgt);
      enc_pos = cnt;
   endtask

   task automatic send_motion_tick();
      int delta, tgt;
      logic [CNT_W-1:0] cnt;
      if ($urandom_range(0, 4) == 0) begin
         send_tick(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      end else begin
         delta = $urandom_range(0, 400);
         cnt = $urandom_range(0, 1) ? enc_pos + 16'(delta) : enc_pos - 16'(delta);
         tgt = 15 * delta + $urandom_range(0, 600) - 300;
         if (tgt < 0) tgt = 0;
         send_tick(cnt, 16'(tgt));
      end
   endtask

   task automatic idle_for(input int n);
      req_tvalid <= 1'b0;
      req_tdata <= $urandom;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] kd,
                              input logic [GAIN_W-1:0] ki);
      csr_we <= 1'b1;
      csr_addr <= REG_KP;
      csr_wdata <= kp;
      @(posedge clock);
      csr_addr <= REG_KD;
      csr_wdata <= kd;
      @(posedge clock);
      csr_addr <= REG_KI;
      csr_wdata <= ki;
      @(posedge clock);
      // An unmapped index must leave every gain untouched.
      csr_addr <= REG_NONE;
      csr_wdata <= 16'($urandom_range(0, 65535));
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.load_gains(kp, kd, ki);
      gain_sets++;
   endtask

   task automatic run_items(input int n, input stim_type kind);
      int sent, burst;
      sent = 0;
      while (sent < n) begin
         burst = $urandom_range(1, 24);
         while (burst > 0 && sent < n) begin
            if (kind == STIM_WINDUP) begin
               if (sent < n - 12) send_tick(enc_pos, GAIN_MAX);
               else send_tick(sent[0] ? 16'hFFFF : 16'h0000, 16'h0000);
            end else begin
               send_motion_tick();
            end
            sent++;
            burst--;
         end
         if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 12));
         if ($urandom_range(0, 40) == 0) drain();
      end
   endtask

   initial begin
      int k;
      tracker = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset gains: zero input, full-scale speed both ways, clamp both ends.
      send_tick(16'h0000, 16'h0000);
      send_tick(16'hFFFF, 16'h0000);
      send_tick(16'hFFFF, 16'hFFFF);
      send_tick(16'hFFFF, 16'h0000);
      send_tick(16'h0000, 16'hFFFF);
      send_tick(16'hAAAA, 16'h5555);
      send_tick(16'h5555, 16'hAAAA);
      send_tick(16'h0000, 16'h0000);
      send_tick(16'h0010, 16'd300);
      send_tick(16'h0020, 16'd600);
      send_tick(16'h0030, 16'd1000);
      send_tick(16'h0030, 16'd2000);
      send_tick(16'h0030, 16'd2000);
      drain();
      write_gains('0, '0, '0);
      send_tick(16'h0030, 16'd500);
      send_tick(16'h0040, 16'hFFFF);
      drain();
      write_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX);
      send_tick(16'h0041, 16'hFFFF);
      send_tick(16'h0041, 16'h0000);
      send_tick(16'hFFFF, 16'h0000);
      send_tick(16'h0000, 16'd15);
      drain();

      for (k = 0; k < 8; k++) begin
         case (k)
            0: write_gains(KP_RESET, KD_RESET, KI_RESET);
            1, 7: write_gains(16'($urandom_range(0, 16384)), 16'($urandom_range(0, 8192)),
                              16'($urandom_range(0, 64)));
            2: write_gains('0, '0, '0);
            3: write_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX);
            4: write_gains('0, '0, GAIN_MAX);
            5: write_gains(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)));
            default: write_gains(16'($urandom_range(2048, 8192)),
                                 16'($urandom_range(0, 4096)),
                                 16'($urandom_range(1, 512)));
         endcase
         case (k)
            0: run_items(200, STIM_MOTION);
            1: run_items(180, STIM_MOTION);
            2: run_items(60, STIM_MOTION);
            3: run_items(120, STIM_MOTION);
            4: run_items(292, STIM_WINDUP);
            5: run_items(130, STIM_MOTION);
            default: run_items(150, STIM_MOTION);
         endcase
         drain();
      end

      req_tvalid <= 1'b0;
      for (k = 0; k < 500 && tracker.pending() != 0; k++) @(posedge clock);
      repeat (8) @(posedge clock);
      if (tracker.pending() != 0)
         tracker.report_mismatch($sformatf("%0d result items never arrived",
                                           tracker.pending()));

      $display("Run covered %0d ticks under %0d gain settings, %0d results checked.",
               tracker.ticks, gain_sets, tracker.checked);
      $display("Drive writes %0d, clamped high %0d, clamped low %0d, integral limits %0d.",
               tracker.writes, tracker.clamp_hi, tracker.clamp_lo, tracker.sat_hits);
      if (tracker.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches.", tracker.errors);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
